[hw/rtl/drift_time_to_radius_calibrator_macros.svh]
// assertion macros for the drift time to radius calibrator
`ifndef DRIFT_TIME_TO_RADIUS_CALIBRATOR_MACROS_SVH
`define DRIFT_TIME_TO_RADIUS_CALIBRATOR_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define DTRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dtrc assertion failed");
// next-cycle implication
`define DTRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dtrc assertion failed");
`else
`define DTRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DTRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/dtrc_pkg.sv]
// shared types, constants and constant functions of the drift calibrator
`timescale 1ns / 1ps
package dtrc_pkg;

    // fixed-point curve constants
    localparam logic [21:0] K1_Q16   = 22'd3741759;
    localparam logic [24:0] C1_Q24   = 25'd27795625;
    localparam logic [22:0] K2_Q8    = 23'd4785625;
    localparam logic [19:0] B1_Q20   = 20'd608330;
    localparam logic [19:0] D2_Q20   = 20'd52521;
    localparam logic [18:0] LOG2_100 = 19'd435412;

    // exponent base: offset of 8 in Q36 minus coef * log2(100)
    localparam logic [63:0] E_BASE_B1 = (64'd1 << 39) - 64'(B1_Q20) * 64'(LOG2_100);
    localparam logic [63:0] E_BASE_D2 = (64'd1 << 39) - 64'(D2_Q20) * 64'(LOG2_100);

    // sigma rounding and scaling: 65536e6 = 2^22 * 15625
    localparam logic [63:0] SIG_RND = 64'd32768000000;
    localparam logic [41:0] SIG_SAT = 42'd1024000000;
    // ceil(2^44 / 15625): (y * SIG_RECIP) >> 44 is floor(y / 15625) for y < 2^30
    localparam logic [30:0] SIG_RECIP = 31'd1125899907;

    localparam int LG_W   = 20;
    localparam int FRAC_W = 16;

    // register reset values
    localparam logic [15:0] TIME_CUT_RST  = 16'd10000;
    localparam logic [15:0] TRANS_RST     = 16'd3830;
    localparam logic [15:0] RES_SCALE_RST = 16'd425;
    localparam logic [15:0] RES_CURV_RST  = 16'd544;
    localparam logic [15:0] RES_CTR_RST   = 16'd12250;

    typedef enum logic [2:0] {
        CFG_TIME_CUT  = 3'd0,
        CFG_TRANS     = 3'd1,
        CFG_RES_SCALE = 3'd2,
        CFG_RES_CURV  = 3'd3,
        CFG_RES_CTR   = 3'd4
    } t_cfg_idx;

    // per-beat sideband carried along the pipeline
    typedef struct packed {
        logic [15:0] t;
        logic        second;
        logic        cut;
    } t_side;

    // integer square root, bit by bit (elaboration only)
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bt;
        x   = v;
        res = '0;
        bt  = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (x >= res + bt) begin
                x   = x - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // factor 2^(2^-k) in Q30
    function automatic logic [31:0] pow_factor(input int k);
        logic [63:0] t;
        t = 64'd1 << 31;
        for (int j = 1; j <= 16; j++) begin
            if (j <= k) t = isqrt64(t << 30);
        end
        return t[31:0];
    endfunction

    function automatic logic [15:0] sat16(input logic [31:0] v);
        return (v > 32'd65535) ? 16'hFFFF : v[15:0];
    endfunction

endpackage

[hw/rtl/dtrc_log.sv]
// log2 of the drift time in Q16, one fraction bit per stage
`timescale 1ns / 1ps
module dtrc_log import dtrc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  t_side           i_side,
    output logic            o_vld,
    output t_side           o_side,
    output logic [LG_W-1:0] o_lg
);
    logic        r_vld  [0:FRAC_W];
    t_side       r_side [0:FRAC_W];
    logic [3:0]  r_exp  [0:FRAC_W];
    logic [30:0] r_man  [0:FRAC_W];
    logic [15:0] r_frac [0:FRAC_W];
    logic [3:0]  n_exp;

    // leading one position
    always_comb begin
        n_exp = '0;
        for (int i = 0; i < 16; i++) begin
            if (i_side.t[i]) n_exp = 4'(i);
        end
    end

    // normalize stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_exp[0]  <= n_exp;
            r_man[0]  <= {15'b0, i_side.t} << (5'd30 - {1'b0, n_exp});
            r_frac[0] <= '0;
        end
    end

    // squaring stages
    for (genvar g = 1; g <= FRAC_W; g++) begin : g_sq
        logic [61:0] n_sq;
        assign n_sq = r_man[g-1] * r_man[g-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= r_vld[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[g] <= r_side[g-1];
                r_exp[g]  <= r_exp[g-1];
                if (n_sq[61]) begin
                    r_man[g]  <= n_sq[61:31];
                    r_frac[g] <= {r_frac[g-1][14:0], 1'b1};
                end else begin
                    r_man[g]  <= n_sq[60:30];
                    r_frac[g] <= {r_frac[g-1][14:0], 1'b0};
                end
            end
        end
    end

    assign o_vld  = r_vld[FRAC_W];
    assign o_side = r_side[FRAC_W];
    assign o_lg   = {r_exp[FRAC_W], r_frac[FRAC_W]};
endmodule

[hw/rtl/dtrc_pow.sv]
// ut^coef in Q24 from log2(t): exponent, 16 factor stages, final shift
`timescale 1ns / 1ps
module dtrc_pow import dtrc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  t_side           i_side,
    input  logic [LG_W-1:0] i_lg,
    output logic            o_vld,
    output t_side           o_side,
    output logic [30:0]     o_p
);
    localparam int LAST = FRAC_W + 2;

    logic        r_vld  [0:LAST];
    t_side       r_side [0:LAST];
    logic [39:0] r_prod;
    logic [4:0]  r_ioff [1:LAST-1];
    logic [15:0] r_f    [1:LAST-1];
    logic [30:0] r_res  [1:LAST-1];
    logic [30:0] r_p;
    logic [40:0] n_e;
    logic [3:0]  n_sh;

    // valid and sideband line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_side[0] <= i_side;
    end

    for (genvar g = 1; g <= LAST; g++) begin : g_line
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= r_vld[g-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) r_side[g] <= r_side[g-1];
        end
    end

    // coef * log2(t)
    always_ff @(posedge i_clk) begin
        if (i_en) r_prod <= i_lg * (i_side.second ? D2_Q20 : B1_Q20);
    end

    // exponent with offset, split into integer and fraction
    assign n_e = {1'b0, r_prod} + (r_side[0].second ? E_BASE_D2[40:0] : E_BASE_B1[40:0]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ioff[1] <= n_e[40:36];
            r_f[1]    <= n_e[35:20];
            r_res[1]  <= 31'h4000_0000;
        end
    end

    // one factor per fraction bit
    for (genvar g = 2; g <= LAST - 1; g++) begin : g_fac
        localparam logic [31:0] TK = pow_factor(g - 1);
        logic [62:0] n_pr;
        assign n_pr = r_res[g-1] * TK;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ioff[g] <= r_ioff[g-1];
                r_f[g]    <= r_f[g-1];
                r_res[g]  <= r_f[g-1][FRAC_W+1-g] ? n_pr[60:30] : r_res[g-1];
            end
        end
    end

    // move to Q24
    assign n_sh = (r_ioff[LAST-1] >= 5'd14) ? 4'd0 : 4'(5'd14 - r_ioff[LAST-1]);

    always_ff @(posedge i_clk) begin
        if (i_en) r_p <= r_res[LAST-1] >> n_sh;
    end

    assign o_vld  = r_vld[LAST];
    assign o_side = r_side[LAST];
    assign o_p    = r_p;
endmodule

[hw/rtl/dtrc_rad.sv]
// radius from the power term: rounding divider for branch one, product for branch two
`timescale 1ns / 1ps
module dtrc_rad import dtrc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  t_side       i_side,
    input  logic [30:0] i_p,
    output logic        o_vld,
    output t_side       o_side,
    output logic [15:0] o_radius
);
    localparam int QB   = 22;
    localparam int LAST = QB + 2;

    logic        r_vld  [0:LAST];
    t_side       r_side [0:LAST];
    logic [37:0] r_num;
    logic [53:0] r_m2;
    logic [31:0] r_den  [0:LAST-1];
    logic [46:0] r_rem  [1:LAST-1];
    logic [QB-1:0] r_quo [1:LAST-1];
    logic [22:0] r_r2   [1:LAST-1];
    logic [15:0] r_radius;
    logic [54:0] n_r2sum;

    // valid and sideband line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_side[0] <= i_side;
    end

    for (genvar g = 1; g <= LAST; g++) begin : g_line
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= r_vld[g-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) r_side[g] <= r_side[g-1];
        end
    end

    // numerator, denominator and branch two product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num    <= i_side.t * K1_Q16;
            r_den[0] <= 32'(i_p) + 32'(C1_Q24);
            r_m2     <= i_p * K2_Q8;
        end
    end

    // rounded dividend and branch two radius
    assign n_r2sum = 55'(r_m2) + (55'd1 << 31);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[1] <= r_den[0];
            r_rem[1] <= 47'({r_num, 8'b0}) + 47'(r_den[0] >> 1);
            r_quo[1] <= '0;
            r_r2[1]  <= n_r2sum[54:32];
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar g = 2; g <= LAST - 1; g++) begin : g_div
        localparam int SH = LAST - 1 - g;
        logic [53:0] n_sub;
        logic        n_ge;
        assign n_sub = 54'(r_den[g-1]) << SH;
        assign n_ge  = 54'(r_rem[g-1]) >= n_sub;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[g] <= r_den[g-1];
                r_r2[g]  <= r_r2[g-1];
                if (n_ge) begin
                    r_rem[g] <= 47'(54'(r_rem[g-1]) - n_sub);
                    r_quo[g] <= r_quo[g-1] | (QB'(1) << SH);
                end else begin
                    r_rem[g] <= r_rem[g-1];
                    r_quo[g] <= r_quo[g-1];
                end
            end
        end
    end

    // branch select and saturation
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_radius <= r_side[LAST-1].second ? sat16(32'(r_r2[LAST-1]))
                                              : sat16(32'(r_quo[LAST-1]));
        end
    end

    assign o_vld    = r_vld[LAST];
    assign o_side   = r_side[LAST];
    assign o_radius = r_radius;
endmodule

[hw/rtl/dtrc_sig.sv]
// resolution a + round(a*b*d^2 / 65536e6) with a reciprocal multiply
`timescale 1ns / 1ps
module dtrc_sig import dtrc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  t_side       i_side,
    input  logic [15:0] i_radius,
    input  logic [15:0] i_res_scale,
    input  logic [15:0] i_res_center,
    input  logic [31:0] i_res_ab,
    output logic        o_vld,
    output t_side       o_side,
    output logic [15:0] o_radius,
    output logic [15:0] o_sigma
);
    localparam int LAST = 5;

    logic        r_vld  [0:LAST];
    t_side       r_side [0:LAST];
    logic [15:0] r_rad  [0:LAST];
    logic [15:0] r_d;
    logic [31:0] r_d2;
    logic [63:0] r_prod;
    logic        r_sat  [3:4];
    logic [29:0] r_y;
    logic [15:0] r_quo;
    logic [15:0] r_sigma;
    logic [63:0] n_sum;
    logic [41:0] n_y;
    logic [60:0] n_qm;
    logic [16:0] n_sig;

    // valid, sideband and radius line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_rad[0]  <= i_radius;
        end
    end

    for (genvar g = 1; g <= LAST; g++) begin : g_line
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= r_vld[g-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[g] <= r_side[g-1];
                r_rad[g]  <= r_rad[g-1];
            end
        end
    end

    // distance, square, product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d    <= (i_radius >= i_res_center) ? i_radius - i_res_center
                                                 : i_res_center - i_radius;
            r_d2   <= r_d * r_d;
            r_prod <= r_d2 * i_res_ab;
        end
    end

    // round and drop the power-of-two part of the divisor
    assign n_sum = r_prod + SIG_RND;
    assign n_y   = n_sum[63:22];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat[3] <= n_y >= SIG_SAT;
            r_y      <= n_y[29:0];
        end
    end

    // divide by 15625 through the reciprocal
    assign n_qm = 61'(r_y) * 61'(SIG_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat[4] <= r_sat[3];
            r_quo    <= n_qm[59:44];
        end
    end

    // add base resolution and saturate
    assign n_sig = 17'(i_res_scale) + 17'(r_quo);

    always_ff @(posedge i_clk) begin
        if (i_en) r_sigma <= r_sat[4] ? 16'hFFFF : sat16(32'(n_sig));
    end

    assign o_vld    = r_vld[LAST];
    assign o_side   = r_side[LAST];
    assign o_radius = r_rad[LAST];
    assign o_sigma  = r_sigma;
endmodule

[hw/rtl/drift_time_to_radius_calibrator.sv]
// Drift time to radius calibrator: takes one drift time per beat and gives the
// calibrated radius and its resolution in micrometres. Throughput is one beat per
// clock unless the output is stalled; the pipeline holds the 16-step
// log2 squaring chain, the 16 power-factor multiplies, the 22-bit rounding
// divider of the first curve branch and the reciprocal multiply of the resolution.
// A stall on the output holds the whole pipeline. Registers are to be written by
// the user only while no beat is in flight; the block itself has no check for
// this. Times at or above the cut give an all-zero result with valid_res low.
`timescale 1ns / 1ps
`include "drift_time_to_radius_calibrator_macros.svh"
module drift_time_to_radius_calibrator import dtrc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] drift_time_ns
    input  logic [0:0]  s_axis_tuser,   // [0] single_branch
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] radius_um, [31:16] sigma_um
    output logic [0:0]  m_axis_tuser    // [0] valid_res
);
    logic [15:0] r_time_cut;
    logic [15:0] r_trans;
    logic [15:0] r_res_scale;
    logic [15:0] r_res_curv;
    logic [15:0] r_res_ctr;
    logic [31:0] r_res_ab;
    logic        r_out_vld;
    logic [31:0] r_out_data;
    logic        r_out_user;

    logic        w_en;
    t_side       n_side;
    logic        w_log_vld;
    t_side       w_log_side;
    logic [LG_W-1:0] w_lg;
    logic        w_pow_vld;
    t_side       w_pow_side;
    logic [30:0] w_p;
    logic        w_rad_vld;
    t_side       w_rad_side;
    logic [15:0] w_radius;
    logic        w_sig_vld;
    t_side       w_sig_side;
    logic [15:0] w_sig_radius;
    logic [15:0] w_sigma;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_cut  <= TIME_CUT_RST;
            r_trans     <= TRANS_RST;
            r_res_scale <= RES_SCALE_RST;
            r_res_curv  <= RES_CURV_RST;
            r_res_ctr   <= RES_CTR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIME_CUT:  r_time_cut  <= i_cfg_data;
                CFG_TRANS:     r_trans     <= i_cfg_data;
                CFG_RES_SCALE: r_res_scale <= i_cfg_data;
                CFG_RES_CURV:  r_res_curv  <= i_cfg_data;
                CFG_RES_CTR:   r_res_ctr   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a*b product of the resolution coefficients
    always_ff @(posedge i_clk) begin
        r_res_ab <= r_res_scale * r_res_curv;
    end

    // pipeline advances unless the output beat is held
    assign w_en          = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_en;

    // branch and cut decisions at entry
    assign n_side.t      = s_axis_tdata;
    assign n_side.second = !s_axis_tuser[0] && (s_axis_tdata > r_trans);
    assign n_side.cut    = s_axis_tdata >= r_time_cut;

    dtrc_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (s_axis_tvalid),
        .i_side  (n_side),
        .o_vld   (w_log_vld),
        .o_side  (w_log_side),
        .o_lg    (w_lg)
    );

    dtrc_pow u_pow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_log_vld),
        .i_side  (w_log_side),
        .i_lg    (w_lg),
        .o_vld   (w_pow_vld),
        .o_side  (w_pow_side),
        .o_p     (w_p)
    );

    dtrc_rad u_rad (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_vld    (w_pow_vld),
        .i_side   (w_pow_side),
        .i_p      (w_p),
        .o_vld    (w_rad_vld),
        .o_side   (w_rad_side),
        .o_radius (w_radius)
    );

    dtrc_sig u_sig (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_vld        (w_rad_vld),
        .i_side       (w_rad_side),
        .i_radius     (w_radius),
        .i_res_scale  (r_res_scale),
        .i_res_center (r_res_ctr),
        .i_res_ab     (r_res_ab),
        .o_vld        (w_sig_vld),
        .o_side       (w_sig_side),
        .o_radius     (w_sig_radius),
        .o_sigma      (w_sigma)
    );

    // output register, cut beats forced to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_sig_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= w_sig_side.cut ? 32'd0 : {w_sigma, w_sig_radius};
            r_out_user <= !w_sig_side.cut;
        end
    end

    assign m_axis_tvalid   = r_out_vld;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_user;

    // checks
    `DTRC_ASSERT_IMP(a_cut_zero, i_clk, i_rst_n, r_out_vld && !r_out_user, r_out_data == 32'd0)
    `DTRC_ASSERT_IMP(a_stall_in, i_clk, i_rst_n, r_out_vld && !m_axis_tready, !s_axis_tready)
    `DTRC_ASSERT_NXT(a_stall_keep, i_clk, i_rst_n, !w_en, r_out_vld)
endmodule
